// ----- sv/cit_pkg.sv -----
package cit_pkg;

    localparam int BYTE_POS_W = 13;
    localparam int TUPLE_POS_W = 9;
    localparam int TUPLE_CNT_W = 7;

    localparam logic [7:0] CODE_END = 8'hFF;
    localparam logic [7:0] CODE_NULL = 8'h00;
    localparam logic [7:0] CODE_MANF = 8'h20;
    localparam logic [7:0] CODE_CONF = 8'h1A;
    localparam logic [7:0] LINK_END = 8'hFF;

    localparam logic [15:0] BASE_DEFAULT = 16'h0400;
    localparam logic [BYTE_POS_W-1:0] BYTE_POS_MAX = {BYTE_POS_W{1'b1}};

    // tuple_position values: code, link, then body bytes 0..3
    localparam logic [TUPLE_POS_W-1:0] TPOS_CODE = 9'd0;
    localparam logic [TUPLE_POS_W-1:0] TPOS_LINK = 9'd1;
    localparam logic [TUPLE_POS_W-1:0] TPOS_BODY0 = 9'd2;
    localparam logic [TUPLE_POS_W-1:0] TPOS_BODY1 = 9'd3;
    localparam logic [TUPLE_POS_W-1:0] TPOS_BODY2 = 9'd4;
    localparam logic [TUPLE_POS_W-1:0] TPOS_BODY3 = 9'd5;
    localparam logic [TUPLE_POS_W-1:0] TPOS_MAX = 9'd257;

    localparam int OUT_TDATA_W = 56;

    typedef enum logic [2:0] {
        CAUSE_END_CODE = 3'd0,
        CAUSE_END_LINK = 3'd1,
        CAUSE_TUPLE_LIM = 3'd2,
        CAUSE_BYTE_LIM = 3'd3,
        CAUSE_STREAM_END = 3'd4
    } t_end_cause;

    // maker id ends up in the lowest bits
    typedef struct packed {
        t_end_cause cause;
        logic [15:0] base;
        logic [15:0] card;
        logic [15:0] maker;
    } t_result;

endpackage

// ----- sv/card_info_tuple_parser.sv -----
// Card information tuple walker.
// Input stream: one even-address attribute memory byte per word, in address
// order. tuser marks the first byte of a scan and clears all parse state;
// tlast marks the final available byte. Bytes arriving while no scan is open
// are dropped without a result.
// Output stream: one word per scan, sent when the walk ends, carrying the
// maker id, card id, config register base and the end cause.
// Throughput is one byte per cycle while tready is high: the tuple walk is a
// single registered step of counters and compares per byte. The result word is
// registered into the output stage, or into the skid stage if that is held.
// The output holds one word plus a one-word skid stage; input tready drops
// only while both are full, i.e. when the receiver stalls on two results.
// Reset leaves the block idle with both output stages empty; the next scan
// starts on a byte with tuser set.
module card_info_tuple_parser #(
    parameter int MAX_TUPLES = 64,
    parameter int BYTE_LIMIT = 6144
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,  // [7:0] tuple_byte
    input  logic                             i_s_tuser,  // [0] first
    input  logic                             i_s_tlast,  // last
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [15:0] manufacturer_id, [31:16] card_id, [47:32] config_base,
    // [50:48] end_cause, [55:51] zero
    output logic [cit_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    logic             accept;
    logic             res_valid;
    cit_pkg::t_result res;
    cit_pkg::t_result out_word;
    logic             buf_ready;

    assign accept = i_s_tvalid && buf_ready;

    cit_parse #(
        .MAX_TUPLES (MAX_TUPLES),
        .BYTE_LIMIT (BYTE_LIMIT)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_first     (i_s_tuser),
        .i_last      (i_s_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cit_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_ready (buf_ready),
        .o_valid (o_m_tvalid),
        .o_data  (out_word),
        .i_ready (i_m_tready)
    );

    assign o_s_tready = buf_ready;
    assign o_m_tdata = {{(cit_pkg::OUT_TDATA_W - $bits(cit_pkg::t_result)){1'b0}}, out_word};

endmodule

// ----- sv/cit_parse.sv -----
module cit_parse #(
    parameter int MAX_TUPLES = 64,
    parameter int BYTE_LIMIT = 6144
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    input  logic              i_last,
    output logic              o_res_valid,
    output cit_pkg::t_result  o_res
);

    localparam logic [cit_pkg::BYTE_POS_W-1:0] BYTE_LIM = cit_pkg::BYTE_POS_W'(BYTE_LIMIT);
    localparam logic [cit_pkg::TUPLE_CNT_W-1:0] TUPLE_LIM = cit_pkg::TUPLE_CNT_W'(MAX_TUPLES);

    logic [cit_pkg::BYTE_POS_W-1:0]  r_bpos, n_bpos;
    logic [cit_pkg::TUPLE_POS_W-1:0] r_tpos, n_tpos;
    logic [7:0]                      r_code, n_code;
    logic [7:0]                      r_link, n_link;
    logic [cit_pkg::TUPLE_CNT_W-1:0] r_count, n_count;
    logic [1:0]                      r_size, n_size;
    logic [15:0]                     r_maker, n_maker;
    logic [15:0]                     r_card, n_card;
    logic [15:0]                     r_base, n_base;
    logic                            r_pend, n_pend;
    logic                            r_done, n_done;

    logic                            hit;
    cit_pkg::t_end_cause             cause;
    logic                            wants;

    always_comb begin
        n_bpos = r_bpos;
        n_tpos = r_tpos;
        n_code = r_code;
        n_link = r_link;
        n_count = r_count;
        n_size = r_size;
        n_maker = r_maker;
        n_card = r_card;
        n_base = r_base;
        n_pend = r_pend;
        n_done = r_done;
        hit = 1'b0;
        cause = cit_pkg::CAUSE_END_CODE;
        wants = 1'b0;

        if (i_accept) begin
            if (i_first) begin
                n_bpos = '0;
                n_tpos = cit_pkg::TPOS_CODE;
                n_code = '0;
                n_link = '0;
                n_count = '0;
                n_size = '0;
                n_maker = '0;
                n_card = '0;
                n_base = cit_pkg::BASE_DEFAULT;
                n_pend = 1'b0;
                n_done = 1'b0;
            end

            if (!n_done) begin
                if (n_bpos != cit_pkg::BYTE_POS_MAX) begin
                    n_bpos = n_bpos + 1'b1;
                end

                priority if (n_tpos == cit_pkg::TPOS_CODE) begin
                    n_code = i_byte;
                    priority if (i_byte == cit_pkg::CODE_END) begin
                        hit = 1'b1;
                        cause = cit_pkg::CAUSE_END_CODE;
                    end else if (i_byte == cit_pkg::CODE_NULL) begin
                        // null tuple: one byte, counts but skips the byte limit check
                        n_count = n_count + 1'b1;
                        if (n_count >= TUPLE_LIM) begin
                            hit = 1'b1;
                            cause = cit_pkg::CAUSE_TUPLE_LIM;
                        end
                    end else begin
                        n_tpos = cit_pkg::TPOS_LINK;
                    end
                end else if (n_tpos == cit_pkg::TPOS_LINK) begin
                    wants = (n_code == cit_pkg::CODE_MANF) || (n_code == cit_pkg::CODE_CONF);
                    n_link = i_byte;
                    if (n_code == cit_pkg::CODE_MANF) begin
                        n_maker = '0;
                        n_card = '0;
                    end else if (n_code == cit_pkg::CODE_CONF) begin
                        n_base = '0;
                        n_size = '0;
                    end
                    n_tpos = cit_pkg::TPOS_BODY0;
                    priority if (i_byte == cit_pkg::LINK_END) begin
                        // end of chain: a wanted tuple ends after body byte 3, others end here
                        n_pend = 1'b1;
                        if (!wants) begin
                            hit = 1'b1;
                            cause = cit_pkg::CAUSE_END_LINK;
                        end
                    end else if (i_byte == 8'h00) begin
                        n_tpos = cit_pkg::TPOS_CODE;
                        n_count = n_count + 1'b1;
                        if (n_bpos >= BYTE_LIM) begin
                            hit = 1'b1;
                            cause = cit_pkg::CAUSE_BYTE_LIM;
                        end else if (n_count >= TUPLE_LIM) begin
                            hit = 1'b1;
                            cause = cit_pkg::CAUSE_TUPLE_LIM;
                        end
                    end else begin
                        n_tpos = cit_pkg::TPOS_BODY0;
                    end
                end else begin
                    if (n_code == cit_pkg::CODE_MANF) begin
                        if (n_tpos == cit_pkg::TPOS_BODY0) n_maker[7:0] = i_byte;
                        if (n_tpos == cit_pkg::TPOS_BODY1) n_maker[15:8] = i_byte;
                        if (n_tpos == cit_pkg::TPOS_BODY2) n_card[7:0] = i_byte;
                        if (n_tpos == cit_pkg::TPOS_BODY3) n_card[15:8] = i_byte;
                    end else if (n_code == cit_pkg::CODE_CONF) begin
                        if (n_tpos == cit_pkg::TPOS_BODY0) n_size = i_byte[1:0];
                        if (n_tpos == cit_pkg::TPOS_BODY2) n_base[7:0] = i_byte;
                        if (n_tpos == cit_pkg::TPOS_BODY3 && n_size != 2'd0) begin
                            n_base[15:8] = i_byte;
                        end
                    end

                    priority if (n_pend && n_tpos == cit_pkg::TPOS_BODY3) begin
                        n_tpos = n_tpos + 1'b1;
                        hit = 1'b1;
                        cause = cit_pkg::CAUSE_END_LINK;
                    end else if ((n_tpos + 1'b1) >= ({1'b0, n_link} + 9'd2)) begin
                        n_tpos = cit_pkg::TPOS_CODE;
                        n_count = n_count + 1'b1;
                        if (n_bpos >= BYTE_LIM) begin
                            hit = 1'b1;
                            cause = cit_pkg::CAUSE_BYTE_LIM;
                        end else if (n_count >= TUPLE_LIM) begin
                            hit = 1'b1;
                            cause = cit_pkg::CAUSE_TUPLE_LIM;
                        end
                    end else begin
                        n_tpos = n_tpos + 1'b1;
                    end
                end

                if (!hit && i_last) begin
                    hit = 1'b1;
                    cause = cit_pkg::CAUSE_STREAM_END;
                end
                if (hit) begin
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpos <= '0;
            r_tpos <= cit_pkg::TPOS_CODE;
            r_code <= '0;
            r_link <= '0;
            r_count <= '0;
            r_size <= '0;
            r_maker <= '0;
            r_card <= '0;
            r_base <= cit_pkg::BASE_DEFAULT;
            r_pend <= 1'b0;
            r_done <= 1'b1;
        end else begin
            r_bpos <= n_bpos;
            r_tpos <= n_tpos;
            r_code <= n_code;
            r_link <= n_link;
            r_count <= n_count;
            r_size <= n_size;
            r_maker <= n_maker;
            r_card <= n_card;
            r_base <= n_base;
            r_pend <= n_pend;
            r_done <= n_done;
        end
    end

    assign o_res_valid = hit;
    assign o_res.maker = n_maker;
    assign o_res.card = n_card;
    assign o_res.base = n_base;
    assign o_res.cause = cause;

`ifndef SYNTHESIS
    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |=> r_done)
        else $error("scan not closed after result");

    a_tpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tpos <= cit_pkg::TPOS_MAX)
        else $error("tuple position out of range");

    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !i_first) |-> !hit)
        else $error("result while idle");
`endif

endmodule

// ----- sv/cit_obuf.sv -----
module cit_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cit_pkg::t_result  i_data,
    output logic              o_ready,
    output logic              o_valid,
    output cit_pkg::t_result  o_data,
    input  logic              i_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    cit_pkg::t_result r_out;
    cit_pkg::t_result r_skid;
    logic             pop;
    logic             load;

    assign pop = r_out_valid && i_ready;
    assign load = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load) begin
            // refill the output word from skid first, else from the parser
            r_out_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (!load && i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data = r_out;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed into full buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid word not moved forward");
`endif

endmodule

// ----- verif/card_info_tuple_parser_tb.sv -----
module card_info_tuple_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TUPLES = 64;
    localparam int BYTE_LIMIT = 6144;
    localparam int ITEMS = 1850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int OUT_W = cit_pkg::OUT_TDATA_W;
    localparam int RES_W = $bits(cit_pkg::t_result);

    // Tracks the tuple walk byte by byte and holds the reports it predicts.
    class scan_scoreboard;
        logic [cit_pkg::BYTE_POS_W-1:0]  pos;
        logic [cit_pkg::TUPLE_POS_W-1:0] tpos;
        logic [7:0]                      code;
        logic [7:0]                      link;
        logic [cit_pkg::TUPLE_CNT_W-1:0] count;
        logic [1:0]                      size;
        logic [15:0]                     maker;
        logic [15:0]                     card;
        logic [15:0]                     base;
        bit                              end_pend;
        bit                              done;
        int                              max_tuples;
        int                              byte_limit;
        int                              mismatches;
        cit_pkg::t_result                scan_reports[$];

        function new(int mt, int bl);
            max_tuples = mt;
            byte_limit = bl;
            mismatches = 0;
            clear_walk();
            done = 1'b1;
        endfunction

        function void clear_walk();
            pos = '0;
            tpos = cit_pkg::TPOS_CODE;
            code = '0;
            link = '0;
            count = '0;
            size = '0;
            maker = '0;
            card = '0;
            base = cit_pkg::BASE_DEFAULT;
            end_pend = 1'b0;
        endfunction

        function int pending();
            return scan_reports.size();
        endfunction

        // Close the current tuple; byte limit wins over tuple limit.
        function bit close_tuple(inout cit_pkg::t_end_cause c);
            tpos = cit_pkg::TPOS_CODE;
            count++;
            if (int'(pos) >= byte_limit) begin
                c = cit_pkg::CAUSE_BYTE_LIM;
                return 1'b1;
            end
            if (int'(count) >= max_tuples) begin
                c = cit_pkg::CAUSE_TUPLE_LIM;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, bit first, bit last);
            cit_pkg::t_end_cause cause;
            bit ended;
            bit wants;
            logic [cit_pkg::TUPLE_POS_W-1:0] k;
            cit_pkg::t_result r;
            ended = 1'b0;
            cause = cit_pkg::CAUSE_END_CODE;
            if (first) begin
                clear_walk();
                done = 1'b0;
            end
            if (done) return;
            if (pos < cit_pkg::BYTE_POS_MAX) pos++;
            if (tpos == cit_pkg::TPOS_CODE) begin
                code = b;
                if (b == cit_pkg::CODE_END) begin
                    ended = 1'b1;
                    cause = cit_pkg::CAUSE_END_CODE;
                end else if (b == cit_pkg::CODE_NULL) begin
                    count++;
                    if (int'(count) >= max_tuples) begin
                        ended = 1'b1;
                        cause = cit_pkg::CAUSE_TUPLE_LIM;
                    end
                end else begin
                    tpos = cit_pkg::TPOS_LINK;
                end
            end else if (tpos == cit_pkg::TPOS_LINK) begin
                wants = (code == cit_pkg::CODE_MANF) || (code == cit_pkg::CODE_CONF);
                link = b;
                if (code == cit_pkg::CODE_MANF) begin
                    maker = '0;
                    card = '0;
                end else if (code == cit_pkg::CODE_CONF) begin
                    base = '0;
                    size = '0;
                end
                tpos = cit_pkg::TPOS_BODY0;
                if (b == cit_pkg::LINK_END) begin
                    end_pend = 1'b1;
                    if (!wants) begin
                        ended = 1'b1;
                        cause = cit_pkg::CAUSE_END_LINK;
                    end
                end else if (b == 8'h00) begin
                    ended = close_tuple(cause);
                end
            end else begin
                k = tpos - cit_pkg::TPOS_BODY0;
                if (code == cit_pkg::CODE_MANF) begin
                    case (k)
                        0: maker[7:0] = b;
                        1: maker[15:8] = b;
                        2: card[7:0] = b;
                        3: card[15:8] = b;
                        default: ;
                    endcase
                end else if (code == cit_pkg::CODE_CONF) begin
                    if (k == 0) size = b[1:0];
                    else if (k == 2) base[7:0] = b;
                    else if (k == 3 && size != 2'd0) base[15:8] = b;
                end
                tpos = tpos + 1'b1;
                if (end_pend && k == 3) begin
                    ended = 1'b1;
                    cause = cit_pkg::CAUSE_END_LINK;
                end else if (int'(tpos) >= int'(link) + 2) begin
                    ended = close_tuple(cause);
                end
            end
            if (!ended && last) begin
                ended = 1'b1;
                cause = cit_pkg::CAUSE_STREAM_END;
            end
            if (!ended) return;
            r.maker = maker;
            r.card = card;
            r.base = base;
            r.cause = cause;
            scan_reports.push_back(r);
            done = 1'b1;
        endfunction

        function void flag(string field, logic [15:0] e, logic [15:0] a);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", field, e, a);
        endfunction

        function void check_result(logic [OUT_W-1:0] word);
            cit_pkg::t_result got;
            cit_pkg::t_result want;
            got = cit_pkg::t_result'(word[RES_W-1:0]);
            if (scan_reports.size() == 0) begin
                flag("unexpected report, manufacturer_id", 16'h0, got.maker);
                return;
            end
            want = scan_reports.pop_front();
            if (got.maker !== want.maker) flag("manufacturer_id", want.maker, got.maker);
            if (got.card !== want.card) flag("card_id", want.card, got.card);
            if (got.base !== want.base) flag("config_base", want.base, got.base);
            if (got.cause !== want.cause)
                flag("end_cause", 16'(want.cause), 16'(got.cause));
            if (word[OUT_W-1:RES_W] !== '0) flag("pad bits", 16'h0, 16'(word[OUT_W-1:RES_W]));
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [7:0]       s_tdata = 8'h00;
    logic             s_tuser = 1'b0;
    logic             s_tlast = 1'b0;
    logic             m_tready = 1'b0;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [OUT_W-1:0] o_m_tdata;

    scan_scoreboard sb;
    bit quiet = 1'b0;
    int sent_items = 0;
    int stall_cycles = 0;

    card_info_tuple_parser #(
        .MAX_TUPLES(MAX_TUPLES),
        .BYTE_LIMIT(BYTE_LIMIT)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(s_tdata),     // [7:0] tuple_byte
        .i_s_tuser(s_tuser),     // [0] first
        .i_s_tlast(s_tlast),     // last
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        // [15:0] manufacturer_id, [31:16] card_id, [47:32] config_base, [50:48] end_cause
        .o_m_tdata(o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && o_s_tready) sb.note_byte(s_tdata, s_tuser, s_tlast);
        if (i_rst_n && o_m_tvalid && m_tready) sb.check_result(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    // Receiver: stall a random number of cycles before each report.
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= first;
        s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sent_items++;
    endtask

    task automatic send_run(input logic [7:0] run[$], input int last_at);
        for (int i = 0; i < run.size(); i++) send_byte(run[i], i == 0, i == last_at);
    endtask

    // Hold the input until every predicted report has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    function automatic void push_tuple(ref logic [7:0] q[$], input logic [7:0] code,
                                       input int link);
        int body;
        body = (link == int'(cit_pkg::LINK_END)) ? 4 : link;
        q.push_back(code);
        q.push_back(8'(link));
        for (int j = 0; j < body; j++) q.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic run_random_scan();
        logic [7:0] q[$];
        logic [7:0] code;
        int n_tuples;
        int link;
        int r;
        int last_at;
        bit crowded;
        crowded = ($urandom_range(0, 9) == 0);
        n_tuples = crowded ? $urandom_range(60, 70) : $urandom_range(1, 8);
        for (int i = 0; i < n_tuples; i++) begin
            r = $urandom_range(0, 9);
            if (r <= 2 || (crowded && $urandom_range(0, 3) != 0)) begin
                q.push_back(cit_pkg::CODE_NULL);
                continue;
            end
            if (r <= 4) code = cit_pkg::CODE_MANF;
            else if (r <= 6) code = cit_pkg::CODE_CONF;
            else code = 8'($urandom_range(1, 254));
            r = $urandom_range(0, 15);
            if (crowded) link = $urandom_range(0, 3);
            else if (r == 0) link = 0;
            else if (r == 1) link = int'(cit_pkg::LINK_END);
            else if (r == 2) link = $urandom_range(9, 40);
            else link = $urandom_range(1, 8);
            push_tuple(q, code, link);
            if (link == int'(cit_pkg::LINK_END)) break;
        end
        r = $urandom_range(0, 3);
        if (r == 0) q.push_back(cit_pkg::CODE_END);
        last_at = (r == 1) ? $urandom_range(0, q.size() - 1) : -1;
        quiet = ($urandom_range(0, 4) == 0);
        send_run(q, last_at);
        // trailing bytes: dropped if the walk has ended, parsed otherwise
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(3, 12))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                      $urandom_range(0, 3) == 0);
    endtask

    initial begin
        logic [7:0] run[$];
        sb = new(MAX_TUPLES, BYTE_LIMIT);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle block: drop bytes that do not start a scan
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);
        run = {cit_pkg::CODE_END};
        send_run(run, -1);
        run = {cit_pkg::CODE_MANF, 8'h04, 8'h34, 8'h12, 8'h78, 8'h56, cit_pkg::CODE_END};
        send_run(run, -1);
        // two-byte base, then the stream ends on a null tuple
        run = {cit_pkg::CODE_CONF, 8'h04, 8'h01, 8'h00, 8'h00, 8'h30, cit_pkg::CODE_NULL};
        send_run(run, run.size() - 1);
        run = {8'h10, cit_pkg::LINK_END};
        send_run(run, -1);
        run = {cit_pkg::CODE_MANF, cit_pkg::LINK_END, 8'hCD, 8'hAB, 8'hFF, 8'hFF};
        send_run(run, -1);
        wait_drained();

        while (sent_items < ITEMS) begin
            if ($urandom_range(0, 11) == 0) run_noise();
            else run_random_scan();
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        quiet = 1'b0;
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/cit_pkg.sv
sv/cit_parse.sv
sv/cit_obuf.sv
sv/card_info_tuple_parser.sv
verif/card_info_tuple_parser_tb.sv
